### hdl/cse_pkg.sv
// shared types, request codes and character constants for the string literal escaper
`timescale 1ns / 1ps

package cse_pkg;

  // longest expansion of one request, and the width of a count up to it
  localparam int unsigned MAX_RUN = 5;
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

  // request type codes
  typedef enum logic [1:0] {
    REQ_DATA  = 2'd0,
    REQ_START = 2'd1,
    REQ_END   = 2'd2
  } req_type_t;

  // characters used by the escapes
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // expansion of one request: characters in output order from index 0
  typedef struct packed {
    logic [RUN_W-1:0]          len;
    logic [MAX_RUN-1:0][7:0]   chars;
  } expansion_t;

endpackage

### hdl/cse_if.sv
// request and result channel interfaces with valid/ready handshake
`timescale 1ns / 1ps

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### hdl/cse_encode.sv
// combinational escape table: one request into its run of output characters
`timescale 1ns / 1ps

module cse_encode
  import cse_pkg::*;
(
  input  logic [1:0]  req_type,
  input  logic [7:0]  in_byte,
  output expansion_t  exp
);

  // lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

  // letter of a two-character escape, zero when there is none
  function automatic logic [7:0] short_letter(input logic [7:0] b);
    logic [7:0] ch;
    case (b)
      8'h09:     ch = 8'h74; // t
      8'h0B:     ch = 8'h76; // v
      8'h08:     ch = 8'h62; // b
      8'h0D:     ch = 8'h72; // r
      8'h0C:     ch = 8'h66; // f
      8'h07:     ch = 8'h61; // a
      CH_BSLASH: ch = CH_BSLASH;
      CH_DQUOTE: ch = CH_DQUOTE;
      8'h00:     ch = 8'h30; // 0
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic [7:0] letter;

  assign letter = short_letter(in_byte);

  // pick the expansion
  always_comb begin
    exp.len   = '0;
    exp.chars = '0;
    case (req_type)
      REQ_START, REQ_END: begin
        exp.len      = RUN_W'(1);
        exp.chars[0] = CH_DQUOTE;
      end
      REQ_DATA: begin
        if (in_byte == CH_NEWLINE) begin
          // newline splits the literal across lines
          exp.len      = RUN_W'(5);
          exp.chars[0] = CH_BSLASH;
          exp.chars[1] = CH_LOWER_N;
          exp.chars[2] = CH_DQUOTE;
          exp.chars[3] = CH_NEWLINE;
          exp.chars[4] = CH_DQUOTE;
        end else if (letter != 8'h00) begin
          exp.len      = RUN_W'(2);
          exp.chars[0] = CH_BSLASH;
          exp.chars[1] = letter;
        end else if (in_byte < CH_SPACE) begin
          exp.len      = RUN_W'(4);
          exp.chars[0] = CH_BSLASH;
          exp.chars[1] = CH_LOWER_X;
          exp.chars[2] = hex_digit(in_byte[7:4]);
          exp.chars[3] = hex_digit(in_byte[3:0]);
        end else begin
          exp.len      = RUN_W'(1);
          exp.chars[0] = in_byte;
        end
      end
      default: begin
        // unused request code gives no characters
        exp.len   = '0;
        exp.chars = '0;
      end
    endcase
  end

endmodule

### hdl/c_string_literal_escaper_top.sv
// top level of the C string literal escaper: escape lookup, expansion register and result register
`timescale 1ns / 1ps

// Each request expands into 1 to 5 characters of literal text (an unused request code into
// none), delivered one per cycle unless the result channel stalls, with last_of_run on the
// final one. A request holding n characters occupies the expansion register until all n
// have drained, so plain bytes and quotes go through at one request per cycle while the
// result channel keeps up, and escapes hold off the request channel meanwhile. The rate is
// set by the expansion register, which drains one character per stall-free cycle into the
// result register, which lets a new request be taken while the previous character waits.

module c_string_literal_escaper_top
  import cse_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  cse_in_if.sink        in_ch,
  cse_out_if.source     out_ch
);

  expansion_t              enc;
  logic                    exp_v_r, exp_v_nxt;
  logic [RUN_W-1:0]        rem_r, rem_nxt;
  logic [MAX_RUN-1:0][7:0] chars_r, chars_nxt;
  logic                    out_v_r, out_v_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    last_r, last_nxt;
  logic                    out_ok, emit, exp_done, in_rdy, in_fire;

  // escape lookup
  cse_encode u_encode (
    .req_type (in_ch.req_type),
    .in_byte  (in_ch.in_byte),
    .exp      (enc)
  );

  // handshake
  assign out_ok   = !out_v_r || out_ch.ready;
  assign emit     = exp_v_r && out_ok;
  assign exp_done = emit && (rem_r == RUN_W'(1));
  assign in_rdy   = !exp_v_r || exp_done;
  assign in_fire  = in_ch.valid && in_rdy;

  // expansion register: load on request, shift out one character per emit
  always_comb begin
    exp_v_nxt = exp_v_r;
    rem_nxt   = rem_r;
    chars_nxt = chars_r;
    if (emit) begin
      rem_nxt   = rem_r - RUN_W'(1);
      chars_nxt = {8'h00, chars_r[MAX_RUN-1:1]};
      if (exp_done) begin
        exp_v_nxt = 1'b0;
      end
    end
    if (in_fire && (enc.len != '0)) begin
      exp_v_nxt = 1'b1;
      rem_nxt   = enc.len;
      chars_nxt = enc.chars;
    end
  end

  // result register
  always_comb begin
    out_v_nxt    = out_v_r;
    out_byte_nxt = out_byte_r;
    last_nxt     = last_r;
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = chars_r[0];
      last_nxt     = (rem_r == RUN_W'(1));
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_v_r <= 1'b0;
      rem_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      exp_v_r <= exp_v_nxt;
      rem_r   <= rem_nxt;
      out_v_r <= out_v_nxt;
    end
    chars_r    <= chars_nxt;
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

  // ports
  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;

  // checks
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    exp_v_r |-> (rem_r != '0))
    else $error("expansion register valid with no characters left");

  a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_v_r && (rem_r > RUN_W'(1))) |-> !in_ch.ready)
    else $error("request taken while an expansion is still draining");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (enc.len != '0)) |=> (exp_v_r && (rem_r == $past(enc.len))))
    else $error("accepted request not loaded into expansion register");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_ch.valid && (out_ch.last_of_run == ($past(rem_r) == RUN_W'(1)))))
    else $error("last_of_run does not match the end of the run");

endmodule

### verif/c_string_literal_escaper_top_test.sv
// self-checking testbench for the C string literal escaper top level
`timescale 1ns / 1ps

module c_string_literal_escaper_top_test
  import cse_pkg::*;
();

  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned TXT_W = MAX_RUN * 8;
  localparam int unsigned RANDOM_REQUESTS = 205;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // one directed request, with its literal text typed in where it is obvious
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       raw;
    logic             typed;
    logic [2:0]       n;
    logic [TXT_W-1:0] txt;
  } stim_row_t;

  // one character of expected literal text
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } lit_char_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

  logic clk;
  logic rst_n;

  cse_in_if  in_ch ();
  cse_out_if out_ch ();

  c_string_literal_escaper_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lit_char_t   pending_chars[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  bit          tx_idle = 1'b0;
  int unsigned burst_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // lowercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h57 + 8'(v));
  endfunction

  // literal text caused by one request, first character in the top byte
  function automatic int unsigned escape_request(input logic [1:0] kind, input logic [7:0] raw,
                                                 output logic [TXT_W-1:0] txt);
    logic [7:0]  letter;
    int unsigned n;
    txt = '0;
    n = 0;
    letter = '0;
    case (kind)
      REQ_START, REQ_END: begin
        txt[TXT_W-1 -: 8] = CH_DQUOTE;
        n = 1;
      end
      REQ_DATA: begin
        case (raw)
          8'h09:     letter = "t";
          8'h0B:     letter = "v";
          8'h08:     letter = "b";
          8'h0D:     letter = "r";
          8'h0C:     letter = "f";
          8'h07:     letter = "a";
          CH_BSLASH: letter = CH_BSLASH;
          CH_DQUOTE: letter = CH_DQUOTE;
          8'h00:     letter = "0";
          default:   letter = '0;
        endcase
        if (raw == CH_NEWLINE) begin
          // newline also splits the literal across lines
          txt = {CH_BSLASH, CH_LOWER_N, CH_DQUOTE, CH_NEWLINE, CH_DQUOTE};
          n = 5;
        end else if (letter != 8'h00) begin
          txt = {CH_BSLASH, letter, 24'h0};
          n = 2;
        end else if (raw < CH_SPACE) begin
          txt = {CH_BSLASH, CH_LOWER_X, hex_char(raw[7:4]), hex_char(raw[3:0]), 8'h00};
          n = 4;
        end else begin
          txt = {raw, 32'h0};
          n = 1;
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] kind, input logic [7:0] raw,
                                       input logic typed, input logic [2:0] n,
                                       input logic [TXT_W-1:0] txt);
    stim_row_t r;
    r.kind = kind;
    r.raw = raw;
    r.typed = typed;
    r.n = n;
    r.txt = txt;
    return r;
  endfunction

  // data byte biased towards text, control bytes and the escaped characters
  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'($urandom_range(32, 126));
      4, 5:       b = 8'($urandom_range(0, 31));
      6: begin
        case ($urandom_range(0, 3))
          0:       b = CH_NEWLINE;
          1:       b = CH_DQUOTE;
          2:       b = CH_BSLASH;
          default: b = 8'h27;
        endcase
      end
      default:    b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // drive one request, wait for its handshake and queue the literal text it causes
  task automatic send_request(input logic [1:0] kind, input logic [7:0] raw,
                              input logic typed, input int unsigned n_typed,
                              input logic [TXT_W-1:0] txt_typed);
    int unsigned gap;
    int unsigned n;
    logic [TXT_W-1:0] txt;
    lit_char_t c;
    if (tx_idle && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.in_byte <= raw;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      n = n_typed;
      txt = txt_typed;
    end else begin
      n = escape_request(kind, raw, txt);
    end
    for (int unsigned i = 0; i < n; i++) begin
      c.ch = txt[TXT_W-1-8*i -: 8];
      c.last = (i == n - 1);
      pending_chars.push_back(c);
    end
  endtask

  // cycle count and overall time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result channel back-pressure
  always @(posedge clk) begin
    case (rx_mode)
      RX_ALWAYS:   out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: out_ch.ready <= ((cycles % 7) >= 3);
      default:     out_ch.ready <= ((cycles % 16) >= 10);
    endcase
  end

  // compare each accepted character with the oldest expected one
  always @(posedge clk) begin : check_results
    lit_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: expected nothing, got byte %02h last %0b",
                 $time, out_ch.out_byte, out_ch.last_of_run);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.out_byte !== want.ch) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.ch, out_ch.out_byte);
          errors++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0b, got %0b",
                   $time, want.last, out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t   directed[$];
    int unsigned counted;
    int unsigned len;
    int unsigned sel;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_DATA;
    in_ch.in_byte = 8'h00;

    // directed: quotes, extremes, every escape class and the ignored code
    directed.push_back(mk_row(REQ_START, 8'hA5, 1'b1, 3'd1, {CH_DQUOTE, 32'h0}));
    directed.push_back(mk_row(REQ_DATA, 8'h00, 1'b1, 3'd2, {CH_BSLASH, "0", 24'h0}));
    directed.push_back(mk_row(REQ_DATA, 8'hFF, 1'b1, 3'd1, {8'hFF, 32'h0}));
    directed.push_back(mk_row(REQ_DATA, CH_NEWLINE, 1'b1, 3'd5,
                              {CH_BSLASH, CH_LOWER_N, CH_DQUOTE, CH_NEWLINE, CH_DQUOTE}));
    directed.push_back(mk_row(REQ_DATA, 8'h01, 1'b1, 3'd4,
                              {CH_BSLASH, CH_LOWER_X, "0", "1", 8'h0}));
    directed.push_back(mk_row(REQ_DATA, 8'h1F, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h09, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h0B, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h08, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h0D, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h0C, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h07, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, CH_BSLASH, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, CH_DQUOTE, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h27, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, CH_SPACE, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h7F, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h80, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h1A, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_DATA, 8'h1B, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_UNUSED, 8'h55, 1'b1, 3'd0, '0));
    directed.push_back(mk_row(REQ_UNUSED, 8'hAA, 1'b1, 3'd0, '0));
    directed.push_back(mk_row(REQ_END, 8'hFF, 1'b1, 3'd1, {CH_DQUOTE, 32'h0}));
    directed.push_back(mk_row(REQ_START, 8'h00, 1'b0, 3'd0, '0));
    directed.push_back(mk_row(REQ_END, 8'h5A, 1'b0, 3'd0, '0));

    // reset
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle = 1'b1;
    rx_mode = RX_RANDOM;
    foreach (directed[i]) begin
      send_request(directed[i].kind, directed[i].raw, directed[i].typed,
                   directed[i].n, directed[i].txt);
    end

    // random: mostly well-formed streams, some broken ones and ignored codes
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        len = $urandom_range(0, 12);
        send_request(REQ_START, 8'($urandom_range(0, 255)), 1'b0, 0, '0);
        repeat (len) send_request(REQ_DATA, random_text_byte(), 1'b0, 0, '0);
        send_request(REQ_END, 8'($urandom_range(0, 255)), 1'b0, 0, '0);
        counted += len + 2;
      end else if (sel < 9) begin
        // stray data, unmatched quotes
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_request(2'($urandom_range(0, 2)), random_text_byte(), 1'b0, 0, '0);
        end
        counted += len;
      end else begin
        send_request(REQ_UNUSED, 8'($urandom_range(0, 255)), 1'b0, 0, '0);
        counted += 1;
      end
    end

    // drain
    in_ch.valid <= 1'b0;
    rx_mode = RX_RANDOM;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
